// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; take it by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PBWL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbwl assertion failed");

// Checked on every edge, reset included.
`define PBWL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pbwl assertion failed");

`endif

// ----- rtl/pbwl_pkg.sv -----
// Constants, types and helpers of the prefix bucketed word lookup unit.
// Depends on nothing; used by the response interface, the top level, the checker and the bench.
package pbwl_pkg;

   localparam int PREFIX_LEN   = 3;
   localparam int MAX_WORD_LEN = 12;
   localparam int DICT_LOG2    = 18;

   localparam int LETTER_W     = 5 * MAX_WORD_LEN;
   localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
   localparam int CNT_W        = DICT_LOG2 + 1;
   localparam int STORE_DEPTH  = 1 << DICT_LOG2;
   localparam int BUCKET_DEPTH = 26 ** PREFIX_LEN;
   localparam int KEY_W        = $clog2(BUCKET_DEPTH);
   localparam int INDEX_W      = 18;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOO_LONG   = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_LETTER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FIN, S_BWAIT, S_SREAD, S_SCMP
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] last;
      logic [CNT_W-1:0] first;
   } bucket_type;

   // Base-26 key of the leading letters; missing letters count as zero.
   function automatic logic [KEY_W-1:0] key_of(input logic [LETTER_W-1:0] l,
                                               input logic [LEN_W-1:0] n);
      logic [KEY_W-1:0] k;
      logic [4:0]       v;
      k = '0;
      for (int j = 0; j < PREFIX_LEN; j++) begin
         v = (LEN_W'(j) < n) ? (l[5*j +: 5] - 5'd1) : 5'd0;
         k = KEY_W'(k * KEY_W'(26)) + KEY_W'(v);
      end
      return k;
   endfunction

endpackage

// ----- rtl/pbwl_req_if.sv -----
// Request and response channel interfaces of the lookup unit.
// Depends on pbwl_pkg for the index width.
interface pbwl_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_code;
   logic       last_char;
   modport source (output valid, req_type, char_code, last_char, input ready);
   modport sink   (input valid, req_type, char_code, last_char, output ready);
endinterface

interface pbwl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          resp_type;
   logic                          found;
   logic [pbwl_pkg::INDEX_W-1:0]  match_index;
   logic [1:0]                    status;
   modport source (output valid, resp_type, found, match_index, status, input ready);
   modport sink   (input valid, resp_type, found, match_index, status, output ready);
endinterface

// ----- rtl/prefix_bucketed_word_lookup_unit.sv -----
// Top level: character assembly, word store, bucket table and bucket scan.
// Depends on pbwl_pkg and the channel interfaces in pbwl_req_if.sv.
//
//  channel | dir | handshake     | word
//  req_ch  | in  | valid / ready | req_type, char_code, last_char
//  rsp_ch  | out | valid / ready | resp_type, found, match_index, status
//
// A final character of a flagged, empty or load word is answered from S_FIN; a query
// goes on through S_BWAIT (bucket read), then scans its bucket word by word in
// S_SREAD (store read) and S_SCMP (compare), answering on a hit or at the bucket end.
// After reset the bucket table is swept clear, one entry a cycle, over all
// 26**PREFIX_LEN = 17576 entries with req_ready low.
// req_ready is low while a final word is processed or a response is stalled.
module prefix_bucketed_word_lookup_unit (
   input logic clock,
   input logic reset,
   pbwl_req_if.sink   req_ch,
   pbwl_rsp_if.source rsp_ch
);

   pbwl_pkg::state_type state_ff, state_in;

   logic [pbwl_pkg::LETTER_W-1:0] buf_letters_ff, buf_letters_in;
   logic [pbwl_pkg::LEN_W-1:0]    buf_len_ff, buf_len_in;
   logic [1:0]                    err_ff, err_in;
   logic [pbwl_pkg::LETTER_W-1:0] fin_letters_ff;
   logic [pbwl_pkg::LEN_W-1:0]    fin_len_ff;
   logic                          fin_type_ff;
   logic [1:0]                    fin_err_ff;
   logic [pbwl_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pbwl_pkg::CNT_W-1:0]    gstart_ff, gstart_in;
   logic [pbwl_pkg::KEY_W-1:0]    gkey_ff, gkey_in;
   logic [pbwl_pkg::KEY_W-1:0]    clr_ff;
   logic [pbwl_pkg::CNT_W-1:0]    scan_i_ff, scan_i_in;
   logic [pbwl_pkg::CNT_W-1:0]    scan_end_ff, scan_end_in;

   logic                          rsp_valid_ff;
   logic                          rsp_type_ff;
   logic                          rsp_found_ff;
   logic [pbwl_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [1:0]                    rsp_status_ff;

   logic [pbwl_pkg::LETTER_W-1:0] store_mem [pbwl_pkg::STORE_DEPTH];
   logic [pbwl_pkg::LETTER_W-1:0] store_rd_ff;
   logic                          store_we;
   pbwl_pkg::bucket_type          bucket_mem [pbwl_pkg::BUCKET_DEPTH];
   pbwl_pkg::bucket_type          bucket_rd_ff, bucket_wdata;
   logic                          bucket_we;
   logic [pbwl_pkg::KEY_W-1:0]    bucket_waddr;

   logic                          accept, clr_done;
   logic [pbwl_pkg::KEY_W-1:0]    key;
   logic                          new_group;
   logic [pbwl_pkg::CNT_W-1:0]    group_first, clamp_end;
   logic [4:0]                    code;
   logic [7:0]                    c;

   logic                          done;
   logic                          done_found;
   logic [pbwl_pkg::INDEX_W-1:0]  done_index;
   logic [1:0]                    done_status;

   assign accept   = req_ch.valid && req_ch.ready;
   assign clr_done = (clr_ff == pbwl_pkg::KEY_W'(pbwl_pkg::BUCKET_DEPTH - 1));
   assign req_ch.ready = (state_ff == pbwl_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign key = pbwl_pkg::key_of(fin_letters_ff, fin_len_ff);
   assign c = req_ch.char_code;

   // Character fold, letter append and first-error capture.
   always_comb begin
      code           = 5'd0;
      err_in         = err_ff;
      buf_letters_in = buf_letters_ff;
      buf_len_in     = buf_len_ff;
      if (c >= 8'd65 && c <= 8'd90) begin
         code = 5'(c - 8'd64);
      end else if (req_ch.req_type == pbwl_pkg::REQ_QUERY && c >= 8'd97 && c <= 8'd122) begin
         code = 5'(c - 8'd96);
      end else if (req_ch.req_type == pbwl_pkg::REQ_LOAD && err_ff == pbwl_pkg::ST_OK) begin
         err_in = pbwl_pkg::ST_BAD_LETTER;
      end
      if (code != 5'd0) begin
         if (buf_len_ff >= pbwl_pkg::LEN_W'(pbwl_pkg::MAX_WORD_LEN)) begin
            if (err_in == pbwl_pkg::ST_OK) begin
               err_in = pbwl_pkg::ST_TOO_LONG;
            end
         end else begin
            for (int k = 0; k < pbwl_pkg::MAX_WORD_LEN; k++) begin
               if (buf_len_ff == pbwl_pkg::LEN_W'(k)) begin
                  buf_letters_in[5*k +: 5] = code;
               end
            end
            buf_len_in = buf_len_ff + pbwl_pkg::LEN_W'(1);
         end
      end
   end

   always_comb begin
      new_group   = (cnt_ff == '0) || (key != gkey_ff);
      group_first = new_group ? cnt_ff : gstart_ff;
      clamp_end   = (bucket_rd_ff.last > cnt_ff) ? cnt_ff : bucket_rd_ff.last;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbwl_pkg::S_CLEAR: if (clr_done) state_in = pbwl_pkg::S_IDLE;
         pbwl_pkg::S_IDLE:  if (accept && req_ch.last_char) state_in = pbwl_pkg::S_FIN;
         pbwl_pkg::S_FIN: begin
            if (fin_err_ff == pbwl_pkg::ST_OK && fin_type_ff == pbwl_pkg::REQ_QUERY &&
                fin_len_ff != '0) begin
               state_in = pbwl_pkg::S_BWAIT;
            end else begin
               state_in = pbwl_pkg::S_IDLE;
            end
         end
         pbwl_pkg::S_BWAIT: state_in = pbwl_pkg::S_SREAD;
         pbwl_pkg::S_SREAD: begin
            state_in = (scan_i_ff < scan_end_ff) ? pbwl_pkg::S_SCMP : pbwl_pkg::S_IDLE;
         end
         pbwl_pkg::S_SCMP: begin
            state_in = (store_rd_ff == fin_letters_ff) ? pbwl_pkg::S_IDLE : pbwl_pkg::S_SREAD;
         end
         default: state_in = pbwl_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory writes, word count, group tracking, scan pointer and the response.
   always_comb begin
      done         = 1'b0;
      done_found   = 1'b0;
      done_index   = '0;
      done_status  = fin_err_ff;
      store_we     = 1'b0;
      bucket_we    = 1'b0;
      bucket_waddr = key;
      bucket_wdata = '{last: cnt_ff + pbwl_pkg::CNT_W'(1), first: group_first};
      cnt_in       = cnt_ff;
      gstart_in    = gstart_ff;
      gkey_in      = gkey_ff;
      scan_i_in    = scan_i_ff;
      scan_end_in  = scan_end_ff;
      unique case (state_ff)
         pbwl_pkg::S_CLEAR: begin
            bucket_we    = 1'b1;
            bucket_waddr = clr_ff;
            bucket_wdata = '0;
         end
         pbwl_pkg::S_FIN: begin
            if (fin_err_ff != pbwl_pkg::ST_OK) begin
               done = 1'b1;
            end else if (fin_type_ff == pbwl_pkg::REQ_LOAD) begin
               done = 1'b1;
               if (cnt_ff[pbwl_pkg::DICT_LOG2]) begin
                  done_status = pbwl_pkg::ST_FULL;
               end else begin
                  store_we   = 1'b1;
                  bucket_we  = 1'b1;
                  gstart_in  = group_first;
                  gkey_in    = key;
                  cnt_in     = cnt_ff + pbwl_pkg::CNT_W'(1);
                  done_index = pbwl_pkg::INDEX_W'(cnt_ff[pbwl_pkg::DICT_LOG2-1:0]);
               end
            end else if (fin_len_ff == '0) begin
               done = 1'b1;
            end
         end
         pbwl_pkg::S_BWAIT: begin
            scan_i_in   = bucket_rd_ff.first;
            scan_end_in = clamp_end;
         end
         pbwl_pkg::S_SREAD: begin
            if (scan_i_ff >= scan_end_ff) done = 1'b1;
         end
         pbwl_pkg::S_SCMP: begin
            if (store_rd_ff == fin_letters_ff) begin
               done       = 1'b1;
               done_found = 1'b1;
               done_index = pbwl_pkg::INDEX_W'(scan_i_ff[pbwl_pkg::DICT_LOG2-1:0]);
            end else begin
               scan_i_in = scan_i_ff + pbwl_pkg::CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pbwl_pkg::S_CLEAR;
         clr_ff         <= '0;
         buf_letters_ff <= '0;
         buf_len_ff     <= '0;
         err_ff         <= '0;
         cnt_ff         <= '0;
         gstart_ff      <= '0;
         gkey_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         gstart_ff <= gstart_in;
         gkey_ff   <= gkey_in;
         if (state_ff == pbwl_pkg::S_CLEAR) clr_ff <= clr_ff + pbwl_pkg::KEY_W'(1);
         if (accept) begin
            // Drop the buffer once the word is handed to the sequencer.
            buf_letters_ff <= req_ch.last_char ? '0 : buf_letters_in;
            buf_len_ff     <= req_ch.last_char ? '0 : buf_len_in;
            err_ff         <= req_ch.last_char ? '0 : err_in;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.last_char) begin
         fin_letters_ff <= buf_letters_in;
         fin_len_ff     <= buf_len_in;
         fin_type_ff    <= req_ch.req_type;
         fin_err_ff     <= err_in;
      end
      scan_i_ff   <= scan_i_in;
      scan_end_ff <= scan_end_in;
      if (done) begin
         rsp_type_ff   <= fin_type_ff;
         rsp_found_ff  <= done_found;
         rsp_index_ff  <= done_index;
         rsp_status_ff <= done_status;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[cnt_ff[pbwl_pkg::DICT_LOG2-1:0]] <= fin_letters_ff;
      store_rd_ff <= store_mem[scan_i_ff[pbwl_pkg::DICT_LOG2-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bucket_we) bucket_mem[bucket_waddr] <= bucket_wdata;
      bucket_rd_ff <= bucket_mem[key];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.resp_type   = rsp_type_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.match_index = rsp_index_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

// ----- rtl/pbwl_checker.sv -----
// Port-level checks of the lookup unit, bound to the top level.
// Depends on assert_macros.svh and pbwl_pkg.
`include "assert_macros.svh"

module pbwl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         resp_type,
   input logic                         found,
   input logic [pbwl_pkg::INDEX_W-1:0] match_index,
   input logic [1:0]                   status
);

   `PBWL_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready)
   `PBWL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_index))
   `PBWL_ASSERT(a_flag_no_index, clock, reset, rsp_valid && status != pbwl_pkg::ST_OK |-> !found && match_index == '0)
   `PBWL_ASSERT(a_found_query, clock, reset, rsp_valid && found |-> resp_type == pbwl_pkg::REQ_QUERY)

endmodule

bind prefix_bucketed_word_lookup_unit pbwl_checker u_pbwl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .resp_type   (rsp_ch.resp_type),
   .found       (rsp_ch.found),
   .match_index (rsp_ch.match_index),
   .status      (rsp_ch.status)
);

// ----- verif/prefix_bucketed_word_lookup_unit_tb.sv -----
// Self-checking bench for the prefix bucketed word lookup unit: directed words, then
// random load batches, queries and broken words.
// Depends on pbwl_pkg, the channel interfaces in pbwl_req_if.sv and the top level.
`timescale 1ns / 1ps

module prefix_bucketed_word_lookup_unit_tb;

   localparam int STORE_WORDS = pbwl_pkg::STORE_DEPTH;
   localparam int CYCLE_LIMIT = 6_000_000;

   typedef struct {
      logic                         rtype;
      logic                         found;
      logic [pbwl_pkg::INDEX_W-1:0] index;
      pbwl_pkg::status_type         st;
   } lookup_result_type;

   typedef struct {
      logic                 rtype;
      bit                   mixed;
      string                text;
      bit                   pinned;
      logic                 found;
      int                   index;
      pbwl_pkg::status_type st;
   } word_row_type;

   logic clock;
   logic reset;
   pbwl_req_if req_ch ();
   pbwl_rsp_if rsp_ch ();

   prefix_bucketed_word_lookup_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow of the block's state
   logic [pbwl_pkg::LETTER_W-1:0] store_mem [int];
   logic [2*pbwl_pkg::CNT_W-1:0]  bucket_mem [int];
   int                            word_cnt;
   int                            run_start;
   int                            run_key;
   logic [pbwl_pkg::LETTER_W-1:0] asm_letters;
   int                            asm_len;
   logic [1:0]                    asm_err;

   lookup_result_type pending_results [$];
   int                error_cnt;
   bit                quiet;
   bit                hold_rq;
   string             dict_words [$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int prefix_key(logic [pbwl_pkg::LETTER_W-1:0] l, int n);
      int k;
      int v;
      k = 0;
      for (int j = 0; j < pbwl_pkg::PREFIX_LEN; j++) begin
         v = (j < n) ? int'(l[5*j +: 5]) - 1 : 0;
         k = k * 26 + v;
      end
      return k;
   endfunction

   // Advance the shadow state by one accepted character; true when a result is due.
   function automatic bit lookup_step(logic rt, logic [7:0] c, logic last,
                                      output lookup_result_type res);
      int                           code;
      int                           key;
      int                           lo;
      int                           hi;
      logic [2*pbwl_pkg::CNT_W-1:0] b;
      code = 0;
      if (c >= 8'd65 && c <= 8'd90) code = c - 64;
      else if (rt == pbwl_pkg::REQ_QUERY && c >= 8'd97 && c <= 8'd122) code = c - 96;
      else if (rt == pbwl_pkg::REQ_LOAD && asm_err == pbwl_pkg::ST_OK)
         asm_err = pbwl_pkg::ST_BAD_LETTER;
      if (code != 0) begin
         if (asm_len >= pbwl_pkg::MAX_WORD_LEN) begin
            if (asm_err == pbwl_pkg::ST_OK) asm_err = pbwl_pkg::ST_TOO_LONG;
         end else begin
            asm_letters[5*asm_len +: 5] = 5'(code);
            asm_len++;
         end
      end
      if (!last) return 1'b0;
      res.rtype = rt;
      res.found = 1'b0;
      res.index = '0;
      res.st    = pbwl_pkg::status_type'(asm_err);
      if (asm_err == pbwl_pkg::ST_OK) begin
         key = prefix_key(asm_letters, asm_len);
         if (rt == pbwl_pkg::REQ_LOAD) begin
            if (word_cnt >= STORE_WORDS) begin
               res.st = pbwl_pkg::ST_FULL;
            end else begin
               store_mem[word_cnt] = asm_letters;
               if (word_cnt == 0 || key != run_key) begin
                  run_start = word_cnt;
                  run_key   = key;
               end
               res.index = pbwl_pkg::INDEX_W'(word_cnt);
               word_cnt++;
               bucket_mem[key] = {pbwl_pkg::CNT_W'(word_cnt), pbwl_pkg::CNT_W'(run_start)};
            end
         end else if (asm_len != 0 && bucket_mem.exists(key)) begin
            b  = bucket_mem[key];
            lo = int'(b[pbwl_pkg::CNT_W-1:0]);
            hi = int'(b[2*pbwl_pkg::CNT_W-1:pbwl_pkg::CNT_W]);
            if (hi > word_cnt) hi = word_cnt;
            for (int i = lo; i < hi; i++) begin
               if (store_mem[i] == asm_letters) begin
                  res.found = 1'b1;
                  res.index = pbwl_pkg::INDEX_W'(i);
                  break;
               end
            end
         end
      end
      asm_letters = '0;
      asm_len     = 0;
      asm_err     = pbwl_pkg::ST_OK;
      return 1'b1;
   endfunction

   function automatic int idle_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_char(logic rt, logic [7:0] c, logic last, bit pinned,
                            lookup_result_type pin);
      lookup_result_type res;
      int                gap;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= rt;
      req_ch.char_code <= c;
      req_ch.last_char <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (lookup_step(rt, c, last, res)) begin
         if (pinned) res = pin;
         pending_results.insert(pending_results.size(), res);
      end
      gap = idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Non-final characters of a mixed word take a random channel type.
   task automatic send_word(logic rt, bit mixed, string s, bit pinned,
                            lookup_result_type pin);
      logic t;
      for (int i = 0; i < s.len(); i++) begin
         t = (mixed && i != s.len() - 1) ? logic'($urandom_range(0, 1)) : rt;
         send_char(t, s[i], i == s.len() - 1, pinned, pin);
      end
   endtask

   function automatic string rand_word(int alpha, int maxlen);
      string s;
      s = "";
      repeat ($urandom_range(1, maxlen))
         s = $sformatf("%s%c", s, 8'(65 + $urandom_range(0, alpha - 1)));
      return s;
   endfunction

   // Fold case at random and scatter non-letters through a query word.
   function automatic string mangle(string w);
      string  s;
      byte    c;
      s = "";
      for (int i = 0; i < w.len(); i++) begin
         if ($urandom_range(0, 9) == 0) begin
            do c = byte'($urandom_range(0, 255));
            while ((c >= 65 && c <= 90) || (c >= 97 && c <= 122) || c == 0);
            s = $sformatf("%s%c", s, c);
         end
         c = w[i];
         if ($urandom_range(0, 1)) c = c + 32;
         s = $sformatf("%s%c", s, c);
      end
      return s;
   endfunction

   // Response side: check, then pick the next ready
   initial begin : rsp_side
      lookup_result_type exp_res;
      int stall;
      int hold;
      stall = 0;
      hold  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected: type %0b found %0b index %0d st %0d",
                        $time, rsp_ch.resp_type, rsp_ch.found, rsp_ch.match_index,
                        rsp_ch.status);
               error_cnt++;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_ch.resp_type !== exp_res.rtype || rsp_ch.found !== exp_res.found ||
                   rsp_ch.match_index !== exp_res.index || rsp_ch.status !== exp_res.st) begin
                  $display("%0t: mismatch: expected type %0b found %0b index %0d st %0d,",
                           $time, exp_res.rtype, exp_res.found, exp_res.index, exp_res.st);
                  $display("%0t:           actual   type %0b found %0b index %0d st %0d",
                           $time, rsp_ch.resp_type, rsp_ch.found, rsp_ch.match_index,
                           rsp_ch.status);
                  error_cnt++;
               end
            end
         end
         if (hold_rq) begin
            hold_rq = 1'b0;
            hold    = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(1, 3);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("prefix_bucketed_word_lookup_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      word_row_type      rows [$];
      lookup_result_type pin;
      string             batch [$];
      string             w;
      int                sent;
      int                sel;

      rows = '{
         '{pbwl_pkg::REQ_QUERY, 0, "ABC",            1, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "A",              1, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "ABC",            1, 0, 1, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "ABCDEFGHIJKL",   1, 0, 2, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "ABCDEFGHIJKLM",  1, 0, 0, pbwl_pkg::ST_TOO_LONG},
         '{pbwl_pkg::REQ_LOAD,  0, "AbC",            1, 0, 0, pbwl_pkg::ST_BAD_LETTER},
         '{pbwl_pkg::REQ_LOAD,  0, "ABCDEFGHIJKLMz", 1, 0, 0, pbwl_pkg::ST_TOO_LONG},
         '{pbwl_pkg::REQ_LOAD,  0, "@",              1, 0, 0, pbwl_pkg::ST_BAD_LETTER},
         '{pbwl_pkg::REQ_LOAD,  0, "\377Z",          1, 0, 0, pbwl_pkg::ST_BAD_LETTER},
         '{pbwl_pkg::REQ_LOAD,  0, "ZZZ",            1, 0, 3, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "abc",            1, 1, 1, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "a",              1, 1, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "zzz",            1, 1, 3, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "ZZY",            1, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "12!",            1, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "{a`@[",          1, 1, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "aBcDeFgHiJkL",   1, 1, 2, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "abcdefghijklmn", 1, 0, 0, pbwl_pkg::ST_TOO_LONG},
         '{pbwl_pkg::REQ_LOAD,  1, "abC",            0, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 1, "ABc",            0, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "ABD",            0, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_LOAD,  0, "ABC",            0, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "ABC",            0, 0, 0, pbwl_pkg::ST_OK},
         '{pbwl_pkg::REQ_QUERY, 0, "zz",             0, 0, 0, pbwl_pkg::ST_OK}
      };

      error_cnt   = 0;
      word_cnt    = 0;
      run_start   = 0;
      run_key     = 0;
      asm_letters = '0;
      asm_len     = 0;
      asm_err     = pbwl_pkg::ST_OK;
      quiet       = 1'b0;
      hold_rq     = 1'b0;
      reset       = 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= pbwl_pkg::REQ_LOAD;
      req_ch.char_code <= '0;
      req_ch.last_char <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         pin = '{rows[i].rtype, rows[i].found, pbwl_pkg::INDEX_W'(rows[i].index), rows[i].st};
         send_word(rows[i].rtype, rows[i].mixed, rows[i].text, rows[i].pinned, pin);
      end
      dict_words = '{"A", "ABC", "ABCDEFGHIJKL", "ZZZ", "ABD"};

      sent = 0;
      while (sent < 2000) begin
         // Fill the pipe against a stalled receiver, later drain completely
         if (sent > 500 && sent < 520) hold_rq = 1'b1;
         if (sent > 1200 && sent < 1220 && pending_results.size() != 0) begin
            req_ch.valid <= 1'b0;
            wait (pending_results.size() == 0);
         end
         quiet = (sent > 800 && sent < 1000);
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            batch = {};
            repeat ($urandom_range(3, 10))
               batch.insert(batch.size(), rand_word($urandom_range(0, 1) ? 4 : 26, 12));
            batch.sort();
            foreach (batch[i]) begin
               send_word(pbwl_pkg::REQ_LOAD, 0, batch[i], 0, pin);
               dict_words.insert(dict_words.size(), batch[i]);
               sent += batch[i].len();
            end
         end else if (sel < 80) begin
            w = ($urandom_range(0, 3) != 0)
                ? dict_words[$urandom_range(0, dict_words.size() - 1)]
                : rand_word(4, 12);
            w = mangle(w);
            send_word(pbwl_pkg::REQ_QUERY, 0, w, 0, pin);
            sent += w.len();
         end else begin
            w = "";
            repeat ($urandom_range(1, 15)) begin
               if ($urandom_range(0, 2) == 0) w = $sformatf("%s%c", w, 8'($urandom_range(1, 255)));
               else w = $sformatf("%s%c", w, 8'($urandom_range(65, 90)));
            end
            send_word(logic'($urandom_range(0, 1)), $urandom_range(0, 1), w, 0, pin);
            if ($urandom_range(0, 7) == 0) begin
               send_char(logic'($urandom_range(0, 1)), 8'd0, 1'b1, 0, pin);
               sent++;
            end
            sent += w.len();
         end
      end

      // Drain, then close with back-to-back queries
      if (pending_results.size() != 0) begin
         req_ch.valid <= 1'b0;
         wait (pending_results.size() == 0);
      end
      quiet = 1'b1;
      send_word(pbwl_pkg::REQ_QUERY, 0, "abc", 0, pin);
      send_word(pbwl_pkg::REQ_QUERY, 0, "zzz", 0, pin);
      req_ch.valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
      if (error_cnt == 0) begin
         $display("prefix_bucketed_word_lookup_unit regression: pass");
      end else begin
         $display("prefix_bucketed_word_lookup_unit regression: fail");
      end
      $finish;
   end

endmodule
